FILE: rtl/pei_pkg.sv
package pei_pkg;

    localparam int unsigned MaxSpeedW = 31;
    localparam int unsigned DampingW  = 16;
    localparam int unsigned KindW     = 2;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 31;

    localparam logic [MaxSpeedW-1:0] MaxSpeedReset = 31'd3276800;
    localparam logic [DampingW-1:0]  DampingReset  = 16'd62259;
    localparam logic [KindW-1:0]     KindReset     = 2'd0;

    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        CMD_ADD_ACCEL = 2'd0,
        CMD_INTEGRATE = 2'd1,
        CMD_SET_POS   = 2'd2,
        CMD_SET_VEL   = 2'd3
    } t_cmd;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MAX_SPEED = 2'd0,
        REG_DAMPING   = 2'd1,
        REG_KIND      = 2'd2
    } t_reg_idx;

    localparam logic [KindW-1:0] KindElectron = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic [19:0]        step_time;
    } t_req;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               speed_limited;
        logic               saturated;
    } t_rsp;

    // classified request from front to back
    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic [19:0]        step_time;
    } t_op;

    function automatic logic signed [31:0] clip(input logic signed [37:0] v,
                                                 inout logic sat);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7FFFFFFF;
            sat = 1'b1;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
            sat = 1'b1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/pei_front.sv
module pei_front #(
    parameter int unsigned Depth = pei_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  pei_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_take,
    output pei_pkg::t_op   o_op
);

    localparam int unsigned PtrW = $clog2(Depth);

    pei_pkg::t_op    r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0]   r_cnt;
    logic            w_push, w_pop;
    pei_pkg::t_op    w_op;

    assign o_full  = (r_cnt == (PtrW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        w_op.cmd       = pei_pkg::t_cmd'(i_req.command);
        w_op.value_x   = i_req.value_x;
        w_op.value_y   = i_req.value_y;
        w_op.step_time = i_req.step_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == PtrW'(Depth-1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == PtrW'(Depth-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wr] <= w_op;
    end

endmodule

FILE: rtl/pei_divider.sv
module pei_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_trial;

    assign o_quot  = r_q;
    assign w_trial = {r_rem, r_q[63]} - {2'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_trial[33]) begin
                    r_rem <= w_trial[32:0];
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_q[63]};
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/pei_back.sv
module pei_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_take,
    input  pei_pkg::t_op                i_op,
    input  logic [pei_pkg::MaxSpeedW-1:0] i_max_speed,
    input  logic [pei_pkg::DampingW-1:0]  i_damping,
    input  logic [pei_pkg::KindW-1:0]     i_kind,
    output logic                        o_empty,
    input  logic                        i_pop,
    output pei_pkg::t_rsp               o_rsp,
    output logic                        o_idle
);

    typedef enum logic [3:0] {
        S_IDLE, S_VEL_X, S_VEL_Y, S_LEN, S_SQRT, S_DIV_X, S_WAIT_X,
        S_DIV_Y, S_WAIT_Y, S_DAMP_X, S_DAMP_Y, S_POS_X, S_POS_Y, S_DONE
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay;
    logic               r_sat, r_lim, r_full;
    pei_pkg::t_op       r_op;
    logic [63:0]        r_len2, r_sq_n, r_sq_res, r_sq_bit;
    logic [31:0]        r_len;
    logic [5:0]         r_sq_cnt;

    // shared multiplier operands
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic signed [37:0] w_rnd;
    logic signed [37:0] w_sum;
    logic               w_sat;
    logic signed [31:0] w_clip;
    logic [31:0]        w_mag_x, w_mag_y, w_mag;
    logic [63:0]        w_dnum;
    logic               w_dstart, w_ddone;
    logic [63:0]        w_dq;
    logic [63:0]        w_sq_t, w_sq_next;
    logic               w_add_sat;
    logic signed [31:0] w_add_x, w_add_y;
    logic               w_load;

    assign o_take  = (r_state == S_IDLE) && i_valid && !r_full;
    assign o_empty = !r_full;
    assign o_idle  = (r_state == S_IDLE) && !i_valid;
    assign w_load  = (r_state == S_DONE) && (!r_full || i_pop);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_sum = '0;
        case (r_state)
            S_VEL_X: begin
                w_ma = 33'(r_ax); w_mb = {13'd0, r_op.step_time}; w_sum = 38'(r_vx);
            end
            S_VEL_Y: begin
                w_ma = 33'(r_ay); w_mb = {13'd0, r_op.step_time}; w_sum = 38'(r_vy);
            end
            S_DAMP_X: begin
                w_ma = 33'(r_vx); w_mb = {17'd0, i_damping};
            end
            S_DAMP_Y: begin
                w_ma = 33'(r_vy); w_mb = {17'd0, i_damping};
            end
            S_POS_X: begin
                w_ma = 33'(r_vx); w_mb = {13'd0, r_op.step_time}; w_sum = 38'(r_px);
            end
            S_POS_Y: begin
                w_ma = 33'(r_vy); w_mb = {13'd0, r_op.step_time}; w_sum = 38'(r_py);
            end
            default: ;
        endcase
    end

    assign w_prod = w_ma * w_mb;
    // round half up, then shift
    assign w_rnd  = 38'((w_prod + 66'sd32768) >>> 16);
    always_comb begin
        w_sat  = r_sat;
        w_clip = pei_pkg::clip(w_sum + w_rnd, w_sat);
    end

    always_comb begin
        w_add_sat = 1'b0;
        w_add_x = pei_pkg::clip(38'(r_ax) + 38'($signed(i_op.value_x)), w_add_sat);
        w_add_y = pei_pkg::clip(38'(r_ay) + 38'($signed(i_op.value_y)), w_add_sat);
    end

    assign w_mag_x  = r_vx[31] ? 32'(-r_vx) : 32'(r_vx);
    assign w_mag_y  = r_vy[31] ? 32'(-r_vy) : 32'(r_vy);
    assign w_mag    = (r_state == S_DIV_X) ? w_mag_x : w_mag_y;
    assign w_dnum   = 64'(w_mag) * 64'(i_max_speed) + 64'(r_len >> 1);
    assign w_dstart = (r_state == S_DIV_X) || (r_state == S_DIV_Y);
    assign w_sq_t   = r_sq_res + r_sq_bit;
    assign w_sq_next = (r_sq_n >= w_sq_t) ? (r_sq_res >> 1) + r_sq_bit : r_sq_res >> 1;

    pei_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (r_len),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= 1'b0;
            r_px <= '0; r_py <= '0; r_vx <= '0; r_vy <= '0; r_ax <= '0; r_ay <= '0;
        end else begin
            if (w_load) begin
                r_full <= 1'b1;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_op  <= i_op;
                        r_lim <= 1'b0;
                        r_sat <= (i_op.cmd == pei_pkg::CMD_ADD_ACCEL) ? w_add_sat : 1'b0;
                        case (i_op.cmd)
                            pei_pkg::CMD_ADD_ACCEL: begin
                                r_ax <= w_add_x; r_ay <= w_add_y; r_state <= S_DONE;
                            end
                            pei_pkg::CMD_SET_POS: begin
                                r_px <= i_op.value_x; r_py <= i_op.value_y; r_state <= S_DONE;
                            end
                            pei_pkg::CMD_SET_VEL: begin
                                r_vx <= i_op.value_x; r_vy <= i_op.value_y; r_state <= S_DONE;
                            end
                            default: r_state <= S_VEL_X;
                        endcase
                    end
                end
                S_VEL_X: begin
                    r_vx <= w_clip; r_sat <= w_sat; r_state <= S_VEL_Y;
                end
                S_VEL_Y: begin
                    r_vy <= w_clip; r_sat <= w_sat;
                    r_state <= (i_kind == pei_pkg::KindElectron) ? S_LEN : S_DAMP_X;
                end
                S_LEN: begin
                    r_len2 <= 64'(w_mag_x) * 64'(w_mag_x) + 64'(w_mag_y) * 64'(w_mag_y);
                    r_sq_res <= '0;
                    r_sq_bit <= 64'd1 << 62;
                    r_sq_cnt <= 6'd32;
                    r_state  <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sq_cnt == 6'd32) begin
                        r_sq_n <= r_len2;
                        if (r_len2 <= 64'(i_max_speed) * 64'(i_max_speed))
                            r_state <= S_POS_X;
                    end else begin
                        if (r_sq_n >= w_sq_t) r_sq_n <= r_sq_n - w_sq_t;
                        r_sq_res <= w_sq_next;
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                    r_sq_cnt <= r_sq_cnt - 1'b1;
                    if (r_sq_cnt == 6'd0) begin
                        r_len   <= w_sq_next[31:0];
                        r_lim   <= 1'b1;
                        r_state <= S_DIV_X;
                    end
                end
                S_DIV_X: r_state <= S_WAIT_X;
                S_WAIT_X: if (w_ddone) begin
                    r_vx <= r_vx[31] ? -32'(w_dq) : 32'(w_dq);
                    r_state <= S_DIV_Y;
                end
                S_DIV_Y: r_state <= S_WAIT_Y;
                S_WAIT_Y: if (w_ddone) begin
                    r_vy <= r_vy[31] ? -32'(w_dq) : 32'(w_dq);
                    r_state <= S_POS_X;
                end
                S_DAMP_X: begin
                    r_vx <= w_rnd[31:0]; r_state <= S_DAMP_Y;
                end
                S_DAMP_Y: begin
                    r_vy <= w_rnd[31:0]; r_state <= S_POS_X;
                end
                S_POS_X: begin
                    r_px <= w_clip; r_sat <= w_sat; r_state <= S_POS_Y;
                end
                S_POS_Y: begin
                    r_py <= w_clip; r_sat <= w_sat;
                    r_ax <= '0; r_ay <= '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        o_rsp.pos_x <= r_px; o_rsp.pos_y <= r_py;
                        o_rsp.vel_x <= r_vx; o_rsp.vel_y <= r_vy;
                        o_rsp.speed_limited <= r_lim;
                        o_rsp.saturated <= r_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/particle_euler_integrator.sv
// Add and set requests go from the accepting state straight to done; integrate
// updates velocity, damps it (electron kind: checks speed against the limit),
// then updates position; when the electron speed clamp fires, a bit-serial square
// root runs, then two divides through one divider. The back end holds one request
// and takes the next once its result is popped; a 2-entry queue decouples the
// push side. Reset is synchronous, active low: state cleared, registers to defaults.
module particle_euler_integrator #(
    parameter int unsigned Depth = pei_pkg::QueueDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  pei_pkg::t_req                 i_req,
    output logic                          empty,
    input  logic                          pop,
    output pei_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [pei_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [pei_pkg::CfgDataW-1:0]  i_cfg_data
);

    logic [pei_pkg::MaxSpeedW-1:0] r_max_speed;
    logic [pei_pkg::DampingW-1:0]  r_damping;
    logic [pei_pkg::KindW-1:0]     r_kind;
    logic                          w_valid, w_take, w_idle;
    pei_pkg::t_op                  w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= pei_pkg::MaxSpeedReset;
            r_damping   <= pei_pkg::DampingReset;
            r_kind      <= pei_pkg::KindReset;
        end else if (i_cfg_we) begin
            case (pei_pkg::t_reg_idx'(i_cfg_idx))
                pei_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg_data;
                pei_pkg::REG_DAMPING:   r_damping <= i_cfg_data[pei_pkg::DampingW-1:0];
                pei_pkg::REG_KIND:      r_kind <= i_cfg_data[pei_pkg::KindW-1:0];
                default: ;
            endcase
        end
    end

    pei_front #(
        .Depth (Depth)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_req   (i_req),
        .o_valid (w_valid),
        .i_take  (w_take),
        .o_op    (w_op)
    );

    pei_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .o_take      (w_take),
        .i_op        (w_op),
        .i_max_speed (r_max_speed),
        .i_damping   (r_damping),
        .i_kind      (r_kind),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_rsp       (o_rsp),
        .o_idle      (w_idle)
    );

`ifndef SYNTHESIS
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_valid) else $error("take without queued request");
    a_idle_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> !w_idle) else $error("back end idle after take");
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        Depth >= 1) else $error("bad queue depth");
`endif

endmodule

FILE: dv/tb.sv
module tb;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         push;
    logic                         full;
    pei_pkg::t_req                i_req;
    logic                         empty;
    logic                         pop;
    pei_pkg::t_rsp                o_rsp;
    logic                         i_cfg_we;
    logic [pei_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [pei_pkg::CfgDataW-1:0] i_cfg_data;

    particle_euler_integrator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .empty      (empty),
        .pop        (pop),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // particle state and register copies
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
    logic [30:0]        lim_speed;
    logic [15:0]        damp;
    logic [1:0]         kind;

    pei_pkg::t_rsp state_q[$];
    int   err_cnt;
    int   stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v, inout logic sat);
        logic signed [31:0] r;
        if (v > 66'sh07FFFFFFF) begin
            r = 32'sh7FFFFFFF;
            sat = 1'b1;
        end else if (v < -66'sh080000000) begin
            r = 32'sh80000000;
            sat = 1'b1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // round(p / 65536), ties toward plus infinity
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_comp(input logic signed [31:0] v,
                                                      input logic [63:0] len);
        logic [95:0] m, q;
        m = (v < 0) ? 96'(-66'(v)) : 96'(v);
        q = (m * 96'(lim_speed) + 96'(len >> 1)) / 96'(len);
        return (v < 0) ? -32'(q) : 32'(q);
    endfunction

    task automatic predict_particle(input pei_pkg::t_req rq);
        logic sat, lim;
        logic signed [65:0] dt;
        logic [63:0] ax, ay, len2, len;
        pei_pkg::t_rsp r;
        sat = 1'b0;
        lim = 1'b0;
        dt = 66'($unsigned(rq.step_time));
        case (pei_pkg::t_cmd'(rq.command))
            pei_pkg::CMD_ADD_ACCEL: begin
                acc_x = sat32(66'(acc_x) + 66'($signed(rq.value_x)), sat);
                acc_y = sat32(66'(acc_y) + 66'($signed(rq.value_y)), sat);
            end
            pei_pkg::CMD_SET_POS: begin
                pos_x = rq.value_x;
                pos_y = rq.value_y;
            end
            pei_pkg::CMD_SET_VEL: begin
                vel_x = rq.value_x;
                vel_y = rq.value_y;
            end
            default: begin
                vel_x = sat32(66'(vel_x) + rnd16(66'(acc_x) * dt), sat);
                vel_y = sat32(66'(vel_y) + rnd16(66'(acc_y) * dt), sat);
                if (kind == pei_pkg::KindElectron) begin
                    ax = (vel_x < 0) ? 64'(-66'(vel_x)) : 64'(vel_x);
                    ay = (vel_y < 0) ? 64'(-66'(vel_y)) : 64'(vel_y);
                    len2 = ax * ax + ay * ay;
                    if (len2 > 64'(lim_speed) * 64'(lim_speed)) begin
                        len = root64(len2);
                        vel_x = clamp_comp(vel_x, len);
                        vel_y = clamp_comp(vel_y, len);
                        lim = 1'b1;
                    end
                end else begin
                    vel_x = 32'(rnd16(66'(vel_x) * 66'(damp)));
                    vel_y = 32'(rnd16(66'(vel_y) * 66'(damp)));
                end
                pos_x = sat32(66'(pos_x) + rnd16(66'(vel_x) * dt), sat);
                pos_y = sat32(66'(pos_y) + rnd16(66'(vel_y) * dt), sat);
                acc_x = 0;
                acc_y = 0;
            end
        endcase
        r.pos_x = pos_x;
        r.pos_y = pos_y;
        r.vel_x = vel_x;
        r.vel_y = vel_y;
        r.speed_limited = lim;
        r.saturated = sat;
        state_q = {state_q, r};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        pei_pkg::t_rsp w;
        if (i_rst_n && pop && !empty) begin
            if (state_q.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_rsp.pos_x), 0);
            end else begin
                w = state_q.pop_front();
                if (o_rsp.pos_x !== w.pos_x) report_mismatch("pos_x", o_rsp.pos_x, w.pos_x);
                if (o_rsp.pos_y !== w.pos_y) report_mismatch("pos_y", o_rsp.pos_y, w.pos_y);
                if (o_rsp.vel_x !== w.vel_x) report_mismatch("vel_x", o_rsp.vel_x, w.vel_x);
                if (o_rsp.vel_y !== w.vel_y) report_mismatch("vel_y", o_rsp.vel_y, w.vel_y);
                if (o_rsp.speed_limited !== w.speed_limited)
                    report_mismatch("speed_limited", 32'(o_rsp.speed_limited),
                                    32'(w.speed_limited));
                if (o_rsp.saturated !== w.saturated)
                    report_mismatch("saturated", 32'(o_rsp.saturated), 32'(w.saturated));
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        int c;
        c = $urandom_range(0, 99);
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= (c < 70);
            2: pop <= (c < 15);
            default: pop <= (($time / 20) % 8) < 5;
        endcase
        if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 3);
    end

    task automatic send_request(input pei_pkg::t_req rq);
        push  <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_particle(rq);
    endtask

    task automatic pause_sender();
        push <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (state_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input pei_pkg::t_reg_idx idx, input logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pei_pkg::REG_MAX_SPEED: lim_speed = val;
            pei_pkg::REG_DAMPING:   damp = val[15:0];
            default:                kind = val[1:0];
        endcase
    endtask

    function automatic pei_pkg::t_req make_req(input pei_pkg::t_cmd c, input logic [31:0] x,
                                               input logic [31:0] y, input logic [19:0] dt);
        pei_pkg::t_req r;
        r.command = c;
        r.value_x = x;
        r.value_y = y;
        r.step_time = dt;
        return r;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
        endcase
    endfunction

    function automatic pei_pkg::t_req rand_req();
        logic [19:0] dt;
        case ($urandom_range(0, 3))
            0: dt = 20'($urandom);
            1: dt = 20'hFFFFF;
            default: dt = 20'($urandom_range(0, 20'h1FFFF));
        endcase
        return make_req(pei_pkg::t_cmd'($urandom_range(0, 3)), rand_q(), rand_q(), dt);
    endfunction

    task automatic test_directed();
        write_reg(pei_pkg::REG_KIND, 31'd0);
        send_request(make_req(pei_pkg::CMD_SET_POS, 32'h7FFFFFFF, 32'h80000000, 20'h0));
        send_request(make_req(pei_pkg::CMD_SET_VEL, 32'h7FFFFFFF, 32'h80000000, 20'hFFFFF));
        send_request(make_req(pei_pkg::CMD_ADD_ACCEL, 32'h7FFFFFFF, 32'h80000000, 20'h0));
        send_request(make_req(pei_pkg::CMD_ADD_ACCEL, 32'h7FFFFFFF, 32'h80000000, 20'h0));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'hFFFFF));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'h0));
        send_request(make_req(pei_pkg::CMD_SET_VEL, 32'h00010000, 32'hFFFF0000, 20'h0));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'h10000));
        drain();
        write_reg(pei_pkg::REG_KIND, 31'd2);
        send_request(make_req(pei_pkg::CMD_SET_VEL, 32'h7FFFFFFF, 32'h80000000, 20'h0));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'h0));
        send_request(make_req(pei_pkg::CMD_SET_VEL, 32'h00300000, 32'h00400000, 20'h0));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'h08000));
        drain();
        write_reg(pei_pkg::REG_MAX_SPEED, 31'd0);
        send_request(make_req(pei_pkg::CMD_SET_VEL, 32'h00000001, 32'hFFFFFFFF, 20'h0));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'h00001));
        drain();
        write_reg(pei_pkg::REG_MAX_SPEED, 31'h7FFFFFFF);
        send_request(make_req(pei_pkg::CMD_SET_VEL, 32'h80000000, 32'h80000000, 20'h0));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'h0));
        drain();
        write_reg(pei_pkg::REG_KIND, 31'd3);
        write_reg(pei_pkg::REG_DAMPING, 31'd0);
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'h1));
        drain();
        write_reg(pei_pkg::REG_DAMPING, 31'hFFFF);
        write_reg(pei_pkg::REG_KIND, 31'd1);
        send_request(make_req(pei_pkg::CMD_SET_VEL, 32'h80000000, 32'h7FFFFFFF, 20'h0));
        send_request(make_req(pei_pkg::CMD_INTEGRATE, 32'h0, 32'h0, 20'hFFFFF));
        drain();
    endtask

    task automatic test_random_phase(input int n);
        int k, burst;
        k = 0;
        while (k < n) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && k < n) begin
                send_request(rand_req());
                burst--;
                k++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
        drain();
    endtask

    task automatic test_random();
        logic [30:0] ms;
        for (int ph = 0; ph < 20; ph++) begin
            case ($urandom_range(0, 3))
                0: ms = 31'h7FFFFFFF;
                1: ms = 0;
                default: ms = 31'($urandom_range(0, 32'h03FFFFFF));
            endcase
            write_reg(pei_pkg::REG_MAX_SPEED, ms);
            write_reg(pei_pkg::REG_DAMPING, ($urandom_range(0, 3) == 0) ? 31'hFFFF :
                      31'($urandom_range(0, 16'hFFFF)));
            write_reg(pei_pkg::REG_KIND, (ph % 2 == 0) ? 31'd2 : 31'($urandom_range(0, 3)));
            stall_mode = ph % 4;
            test_random_phase(85);
        end
    endtask

    initial begin
        err_cnt    = 0;
        stall_mode = 0;
        pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; acc_x = 0; acc_y = 0;
        lim_speed = pei_pkg::MaxSpeedReset;
        damp      = pei_pkg::DampingReset;
        kind      = pei_pkg::KindReset;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && state_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
